@@ rtl/bol_pkg.sv @@
// shared constants and operation codes of the bounded ordered list
package bol_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int ENTRY_WIDTH_DEF = 32;

	localparam int FUNC_W  = 3;
	localparam int POS_W   = 6;
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 7;
	localparam int CAP_W   = 7;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ_AT    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_ERASE_AT   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ_LAST  = 3'd4;

	// register select is paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

endpackage

@@ rtl/bounded_ordered_list.sv @@
// bounded ordered list: entries in a ram, one shared index adder shifts them one word at a time
// push back, reads, refused words and erase of the last entry go straight to done
// push front: one read and one write state per entry moved, then the new entry at index 0
// erase at index: each entry above the position moves down through the single ram port pair
// input held off while an operation runs and until the result word is taken
// reset clears the count and sets capacity to 64; ram contents stay undefined until written
module bounded_ordered_list
	import bol_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic [POS_W-1:0]   position,
	input  logic [WORD_W-1:0]  entry_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic [WORD_W-1:0]  entry_out,
	output logic [COUNT_W-1:0] count,
	output logic               full_res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > CAP_W) ? FW : CAP_W;
	localparam int XW = (ENTRY_WIDTH > WORD_W) ? ENTRY_WIDTH : WORD_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SH_RD = 5'b00010,
		ST_SH_WR = 5'b00100,
		ST_INS   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                 st_q;
	logic [FW-1:0]          fill_q;
	logic [CAP_W-1:0]       capacity_q;
	logic [AW-1:0]          idx_q;
	logic                   down_q;
	logic [ENTRY_WIDTH-1:0] data_q;
	logic                   refused_q;
	logic                   rdsel_q;
	logic                   out_valid_q;
	logic                   status_q;
	logic [WORD_W-1:0]      entry_out_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   full_q;

	logic                   accept;
	logic                   cfg_wr;
	logic [CW-1:0]          fill_ext;
	logic [CW-1:0]          cap_eff;
	logic [CW-1:0]          pos_ext;
	logic                   is_full;
	logic                   pos_bad;
	logic [AW-1:0]          nb;
	logic                   sh_end;
	logic [XW-1:0]          in_ext;
	logic [XW-1:0]          rd_ext;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [ENTRY_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [ENTRY_WIDTH-1:0] ram_rdata;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// operation checks
	assign fill_ext = CW'(fill_q);
	assign cap_eff  = (CW'(capacity_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity_q);
	assign pos_ext  = CW'(position);
	assign is_full  = fill_ext >= cap_eff;
	assign pos_bad  = pos_ext >= fill_ext;

	assign in_ready = (st_q == ST_IDLE) && !out_valid_q;
	assign accept   = in_valid && in_ready;

	assign in_ext = XW'(entry_in);
	assign rd_ext = XW'(ram_rdata);

	// shared index unit: neighbor of the entry being written
	assign nb     = down_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
	assign sh_end = down_q ? (nb == '0) : ((CW'(nb) + CW'(1)) >= fill_ext);

	// ram port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = nb;
		case (st_q)
			ST_IDLE: begin
				ram_waddr = fill_q[AW-1:0];
				ram_wdata = in_ext[ENTRY_WIDTH-1:0];
				if (accept) begin
					case (func)
						FUNC_PUSH_BACK: begin
							ram_we = !is_full;
						end
						FUNC_PUSH_FRONT: begin
							ram_we = !is_full && (fill_q == '0);
						end
						FUNC_READ_AT: begin
							ram_re    = !pos_bad;
							ram_raddr = pos_ext[AW-1:0];
						end
						FUNC_READ_LAST: begin
							ram_re    = (fill_q != '0);
							ram_raddr = fill_q[AW-1:0] - AW'(1);
						end
						default: begin
							ram_we = 1'b0;
						end
					endcase
				end
			end
			ST_SH_RD: begin
				ram_re = 1'b1;
			end
			ST_SH_WR: begin
				ram_we = 1'b1;
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = data_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bol_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			fill_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_DONE;
						case (func)
							FUNC_PUSH_BACK: begin
								if (!is_full) begin
									fill_q <= fill_q + FW'(1);
								end
							end
							FUNC_PUSH_FRONT: begin
								if (!is_full) begin
									if (fill_q == '0) begin
										fill_q <= fill_q + FW'(1);
									end else begin
										st_q <= ST_SH_RD;
									end
								end
							end
							FUNC_ERASE_AT: begin
								if (!pos_bad) begin
									if ((pos_ext + CW'(1)) < fill_ext) begin
										st_q <= ST_SH_RD;
									end else begin
										fill_q <= fill_q - FW'(1);
									end
								end
							end
							default: begin
								st_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SH_RD: begin
					st_q <= ST_SH_WR;
				end
				ST_SH_WR: begin
					if (sh_end) begin
						if (down_q) begin
							st_q <= ST_INS;
						end else begin
							st_q   <= ST_DONE;
							fill_q <= fill_q - FW'(1);
						end
					end else begin
						st_q <= ST_SH_RD;
					end
				end
				ST_INS: begin
					st_q   <= ST_DONE;
					fill_q <= fill_q + FW'(1);
				end
				ST_DONE: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operation context, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= in_ext[ENTRY_WIDTH-1:0];
			down_q <= (func == FUNC_PUSH_FRONT);
			if (func == FUNC_PUSH_FRONT) begin
				idx_q <= fill_q[AW-1:0];
			end else begin
				idx_q <= pos_ext[AW-1:0];
			end
			case (func)
				FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
					refused_q <= is_full;
					rdsel_q   <= 1'b0;
				end
				FUNC_READ_AT: begin
					refused_q <= pos_bad;
					rdsel_q   <= !pos_bad;
				end
				FUNC_ERASE_AT: begin
					refused_q <= pos_bad;
					rdsel_q   <= 1'b0;
				end
				FUNC_READ_LAST: begin
					refused_q <= (fill_q == '0);
					rdsel_q   <= (fill_q != '0);
				end
				default: begin
					refused_q <= 1'b1;
					rdsel_q   <= 1'b0;
				end
			endcase
		end else if (st_q == ST_SH_WR) begin
			idx_q <= nb;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_DONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DONE) begin
			status_q    <= refused_q;
			entry_out_q <= rdsel_q ? rd_ext[WORD_W-1:0] : '0;
			count_q     <= fill_ext[COUNT_W-1:0];
			full_q      <= is_full;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign entry_out = entry_out_q;
	assign count     = count_q;
	assign full_res  = full_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill above depth");

	a_refused_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && refused_q) |-> $stable(fill_q))
		else $error("refused word changed the fill");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_DONE))
		else $error("result word without finished operation");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && !accept) |-> !ram_we)
		else $error("ram written with no operation running");

endmodule

@@ rtl/bol_ram.sv @@
// generic single-port-write ram with registered read
module bol_ram
	import bol_pkg::*;
#(
	parameter int WIDTH = ENTRY_WIDTH_DEF,
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
